// ===== sv/water_column_wave_step_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Water column wave step unit: assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WATER_COLUMN_WAVE_STEP_UNIT_DEFINES_SVH
`define WATER_COLUMN_WAVE_STEP_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WCWS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WCWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/wcws_pkg.sv =====
// ----------------------------------------------------------------------------
// Water column wave step package
// Shared sizes, fixed-point constants, port types and a saturation helper function.
// ----------------------------------------------------------------------------
package wcws_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MIN_COLUMNS = 3;
    localparam int COL_AW      = $clog2(MAX_COLUMNS);
    localparam int COUNT_W     = COL_AW + 1;

    // Configuration register map and field widths.
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_SLOPE_W   = 31;
    localparam int CFG_WIDTH_W   = 31;
    localparam int CFG_COUNT_W   = 7;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SLOPE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_WIDTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 2'd2;
    localparam logic [CFG_SLOPE_W-1:0] MAX_SLOPE_RESET    = 31'd65536;
    localparam logic [CFG_WIDTH_W-1:0] COLUMN_WIDTH_RESET = 31'd65536;
    localparam logic [CFG_COUNT_W-1:0] COLUMN_COUNT_RESET = 7'd64;

    // Operation codes.
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_PERTURB = 1'b1;

    // Q16.16 constants.
    localparam logic signed [31:0] FIX_ONE  = 32'sd65536;
    localparam logic [16:0] DAMP_Q16        = 17'd64881;
    localparam logic [16:0] NEAR_Q16        = 17'd52429;
    localparam logic [16:0] FAR_Q16         = 17'd26214;
    localparam logic signed [34:0] SPREAD_LIMIT = 35'sd6554;
    localparam logic signed [35:0] SAT_MAX  = 36'sh0_7FFF_FFFF;
    localparam logic signed [35:0] SAT_MIN  = 36'shF_8000_0000;

    typedef struct packed {
        logic               operation;
        logic [15:0]        time_step;
        logic [31:0]        position;
        logic signed [31:0] amount;
    } request_t;

    typedef struct packed {
        logic [COL_AW-1:0]  column_index;
        logic signed [31:0] height;
        logic               surface_active;
        logic               last;
    } result_t;

    // Column memory: height and velocity of each column in one word.
    typedef struct packed {
        logic              en;
        logic [COL_AW-1:0] addr;
    } mem_rd_t;

    typedef struct packed {
        logic               we_h;
        logic               we_v;
        logic [COL_AW-1:0]  addr;
        logic signed [31:0] h;
        logic signed [31:0] v;
    } col_wr_t;

    typedef struct packed {
        logic               en;
        logic [COL_AW-1:0]  addr;
        logic signed [31:0] data;
    } nh_wr_t;

    // Write-back of one finished column from the update pipeline.
    typedef struct packed {
        logic               en;
        logic [COL_AW-1:0]  addr;
        logic signed [31:0] vel;
        logic signed [31:0] nh;
    } pipe_wr_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
        logic signed [31:0] r;
        if (x > SAT_MAX)
            r = SAT_MAX[31:0];
        else if (x < SAT_MIN)
            r = SAT_MIN[31:0];
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

// ===== sv/wcws_state_mem.sv =====
// ----------------------------------------------------------------------------
// Water column wave step state memories
// Column memory (height, velocity) and new-height memory, registered reads.
// ----------------------------------------------------------------------------
module wcws_state_mem
    import wcws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mem_rd_t            col_rd,
    input  col_wr_t            col_wr,
    input  mem_rd_t            nh_rd,
    input  nh_wr_t             nh_wr,
    output logic signed [31:0] col_h,
    output logic signed [31:0] col_v,
    output logic signed [31:0] nh_data
);

    logic [63:0] col_mem [MAX_COLUMNS];
    logic [31:0] nh_mem  [MAX_COLUMNS];

    logic [63:0]            col_rd_reg;
    logic [31:0]            nh_rd_reg;
    logic [MAX_COLUMNS-1:0] h_valid_reg;
    logic [MAX_COLUMNS-1:0] v_valid_reg;
    logic                   h_ok_reg;
    logic                   v_ok_reg;

    always_ff @(posedge clk)
    begin
        if (col_wr.we_h)
        begin
            col_mem[col_wr.addr][63:32] <= col_wr.h;
        end
        if (col_wr.we_v)
        begin
            col_mem[col_wr.addr][31:0] <= col_wr.v;
        end
        if (col_rd.en)
        begin
            col_rd_reg <= col_mem[col_rd.addr];
        end
        if (nh_wr.en)
        begin
            nh_mem[nh_wr.addr] <= nh_wr.data;
        end
        if (nh_rd.en)
        begin
            nh_rd_reg <= nh_mem[nh_rd.addr];
        end
    end

    // Heights and velocities read as zero until first written after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= '0;
            v_valid_reg <= '0;
            h_ok_reg    <= 1'b0;
            v_ok_reg    <= 1'b0;
        end
        else
        begin
            if (col_wr.we_h)
            begin
                h_valid_reg[col_wr.addr] <= 1'b1;
            end
            if (col_wr.we_v)
            begin
                v_valid_reg[col_wr.addr] <= 1'b1;
            end
            if (col_rd.en)
            begin
                h_ok_reg <= h_valid_reg[col_rd.addr];
                v_ok_reg <= v_valid_reg[col_rd.addr];
            end
        end
    end

    assign col_h   = h_ok_reg ? $signed(col_rd_reg[63:32]) : 32'sd0;
    assign col_v   = v_ok_reg ? $signed(col_rd_reg[31:0]) : 32'sd0;
    assign nh_data = $signed(nh_rd_reg);

endmodule

// ===== sv/wcws_divider.sv =====
// ----------------------------------------------------------------------------
// Water column wave step divider
// Restoring divider, one quotient bit per cycle, for the hit column index.
// ----------------------------------------------------------------------------
module wcws_divider
    import wcws_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [31:0]            dividend,
    input  logic [CFG_WIDTH_W-1:0] divisor,
    output logic                   done,
    output logic [31:0]            quotient
);

    localparam int DIV_W = 32;
    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] count_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [DIV_W-1:0] shifted;
    logic             fits;

    // The remainder stays below the divisor, so its top bit is free to shift.
    assign shifted = {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
    assign fits    = (shifted >= dvs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= DIV_W'(divisor);
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (shifted - dvs_reg) : shifted;
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/wcws_column_pipe.sv =====
// ----------------------------------------------------------------------------
// Water column wave step column pipeline
// Neighbor window, offset, dt scaling, clamp, damping and new height.
// ----------------------------------------------------------------------------
module wcws_column_pipe
    import wcws_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   clear,
    input  logic                   feed_valid,
    input  logic [COUNT_W-1:0]     feed_idx,
    input  logic [COUNT_W-1:0]     n_used,
    input  logic signed [31:0]     rd_h,
    input  logic signed [31:0]     rd_v,
    input  logic [15:0]            time_step,
    input  logic [CFG_SLOPE_W-1:0] max_slope,
    output pipe_wr_t               wr,
    output logic                   busy,
    output logic                   spread_small
);

    // Sliding window over the stream of column words.
    logic signed [31:0] prev_h_reg;
    logic signed [31:0] cur_h_reg;
    logic signed [31:0] cur_v_reg;

    logic signed [31:0] left_w;
    logic signed [31:0] right_w;
    logic signed [33:0] sum_w;
    logic signed [33:0] half_w;
    logic signed [33:0] off_w;
    logic [COUNT_W-1:0] col_w;
    logic               emit;

    logic               s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [COL_AW-1:0]  s0_col_reg, s1_col_reg, s2_col_reg, s3_col_reg, s4_col_reg;
    logic signed [31:0] s0_u_reg, s1_u_reg, s2_u_reg, s3_u_reg, s4_u_reg;
    logic signed [31:0] s0_v_reg, s1_v_reg, s2_v_reg;
    logic signed [33:0] s0_off_reg;
    logic signed [50:0] s1_prod_reg;
    logic signed [31:0] s2_s_reg;
    logic signed [31:0] s3_v_reg;
    logic signed [48:0] s4_prod_reg;

    logic signed [33:0] mn_reg;
    logic signed [33:0] mx_reg;

    logic signed [50:0] prod1_w;
    logic signed [34:0] scaled_w;
    logic signed [35:0] sc36_w;
    logic signed [35:0] lim_w;
    logic signed [35:0] clamp_w;
    logic signed [35:0] vsum_w;
    logic signed [48:0] prod2_w;
    logic signed [31:0] vnew_w;
    logic signed [34:0] spread_w;

    // A word arriving for index k completes the window of column k-1.
    assign emit    = feed_valid && (feed_idx != '0);
    assign col_w   = feed_idx - COUNT_W'(1);
    assign left_w  = (feed_idx == COUNT_W'(1)) ? FIX_ONE : prev_h_reg;
    assign right_w = (feed_idx >= n_used) ? FIX_ONE : rd_h;
    assign sum_w   = $signed({{2{left_w[31]}}, left_w}) + $signed({{2{right_w[31]}}, right_w});
    // Halving rounds toward zero.
    assign half_w  = (sum_w + $signed({33'd0, sum_w[33]})) >>> 1;
    assign off_w   = half_w - ($signed({{2{cur_h_reg[31]}}, cur_h_reg}) <<< 1);

    assign prod1_w  = s0_off_reg * $signed({1'b0, time_step});
    assign scaled_w = s1_prod_reg[50:16];
    assign sc36_w   = $signed({scaled_w[34], scaled_w});
    assign lim_w    = $signed({5'd0, max_slope});

    always_comb
    begin
        if (sc36_w > lim_w)
            clamp_w = lim_w;
        else if (sc36_w < -lim_w)
            clamp_w = -lim_w;
        else
            clamp_w = sc36_w;
    end

    assign vsum_w  = $signed({{4{s2_s_reg[31]}}, s2_s_reg}) + $signed({{4{s2_v_reg[31]}}, s2_v_reg});
    assign prod2_w = s3_v_reg * $signed(DAMP_Q16);
    assign vnew_w  = s4_prod_reg[47:16];

    always_ff @(posedge clk)
    begin
        if (feed_valid)
        begin
            prev_h_reg <= cur_h_reg;
            cur_h_reg  <= rd_h;
            cur_v_reg  <= rd_v;
        end

        s0_off_reg <= off_w;
        s0_u_reg   <= cur_h_reg;
        s0_v_reg   <= cur_v_reg;
        s0_col_reg <= col_w[COL_AW-1:0];

        s1_prod_reg <= prod1_w;
        s1_u_reg    <= s0_u_reg;
        s1_v_reg    <= s0_v_reg;
        s1_col_reg  <= s0_col_reg;

        s2_s_reg   <= clamp_w[31:0];
        s2_u_reg   <= s1_u_reg;
        s2_v_reg   <= s1_v_reg;
        s2_col_reg <= s1_col_reg;

        s3_v_reg   <= sat32(vsum_w);
        s3_u_reg   <= s2_u_reg;
        s3_col_reg <= s2_col_reg;

        s4_prod_reg <= prod2_w;
        s4_u_reg    <= s3_u_reg;
        s4_col_reg  <= s3_col_reg;

        if (clear)
        begin
            mn_reg <= '0;
            mx_reg <= '0;
        end
        else if (s0_valid_reg)
        begin
            if (s0_off_reg < mn_reg)
                mn_reg <= s0_off_reg;
            else if (s0_off_reg > mx_reg)
                mx_reg <= s0_off_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= emit;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_comb
    begin
        wr.en   = s4_valid_reg;
        wr.addr = s4_col_reg;
        wr.vel  = vnew_w;
        wr.nh   = sat32($signed({{4{s4_u_reg[31]}}, s4_u_reg}) + $signed({{4{vnew_w[31]}}, vnew_w}));
    end

    assign busy = s0_valid_reg || s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg;

    assign spread_w     = $signed({mx_reg[33], mx_reg}) - $signed({mn_reg[33], mn_reg});
    assign spread_small = (spread_w < SPREAD_LIMIT);

endmodule

// ===== sv/water_column_wave_step_unit.sv =====
// ----------------------------------------------------------------------------
// Water column wave step unit
// Sequencer, configuration registers and result stage of the water surface.
// ----------------------------------------------------------------------------
// A tick on an active surface keeps the request side stalled through two passes:
// one pass reads one column word a cycle from the column memory into the update
// pipeline, then a second pass reads one word a cycle, while results are taken, to
// commit heights and send one result per column. The single read port of each
// memory sets this pace. A tick on an inactive surface only runs the result pass.
// A perturb request waits for the bit-serial divider that finds the hit column,
// followed by up to five height writes. Heights and velocities read as zero after
// reset through per-column valid flags, so there is no clearing pass. A new
// request is taken while the final result still waits in the output register.
`include "water_column_wave_step_unit_defines.svh"

module water_column_wave_step_unit
    import wcws_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   request_valid,
    output logic                   request_stall,
    input  request_t               request,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_PERT   = 3'd2;
    localparam logic [2:0] ST_COMP   = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    localparam int TGT_W = 34;
    localparam logic [COUNT_W-1:0] HIT_SLOT   = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] LAST_SLOT  = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] PROD_STEPS = COUNT_W'(2);

    logic [2:0]         state_reg, state_next;
    logic [COUNT_W-1:0] slot_reg, slot_next;
    logic               active_reg, active_next;
    logic               commit_reg, commit_next;
    logic               rd_pending_reg, rd_pending_next;
    logic               out_valid_reg, out_valid_next;
    logic               feed_valid_reg;
    logic [COUNT_W-1:0] feed_idx_reg;
    logic [COL_AW-1:0]  pend_idx_reg;
    result_t            out_reg;

    logic [CFG_SLOPE_W-1:0] max_slope_reg;
    logic [CFG_WIDTH_W-1:0] column_width_reg;
    logic [CFG_COUNT_W-1:0] column_count_reg;

    logic [15:0]        dt_reg;
    logic signed [31:0] amt_reg;
    logic signed [31:0] near_reg;
    logic signed [31:0] far_reg;

    logic               request_accept;
    logic               cfg_accept;
    logic [COUNT_W-1:0] n_used;
    logic               div_start;
    logic               div_done;
    logic [31:0]        hit_col;
    logic               pipe_clear;
    logic               pipe_busy;
    logic               spread_small;
    pipe_wr_t           pipe_wr;
    logic               move;
    logic               issue;

    logic [16:0]            coef_w;
    logic signed [48:0]     pert_prod_w;
    logic signed [TGT_W-1:0] target_w;
    logic                   target_in_row;
    logic signed [31:0]     pert_h_w;

    mem_rd_t            col_rd;
    col_wr_t            col_wr;
    mem_rd_t            nh_rd;
    nh_wr_t             nh_wr;
    logic signed [31:0] col_h;
    logic signed [31:0] col_v;
    logic signed [31:0] nh_data;

    assign request_accept = request_valid && !request_stall;
    assign request_stall  = (state_reg != ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign cfg_accept     = cfg_valid && cfg_ready;

    always_comb
    begin
        if (column_count_reg < CFG_COUNT_W'(MIN_COLUMNS))
            n_used = COUNT_W'(MIN_COLUMNS);
        else if (column_count_reg > CFG_COUNT_W'(MAX_COLUMNS))
            n_used = COUNT_W'(MAX_COLUMNS);
        else
            n_used = COUNT_W'(column_count_reg);
    end

    // Perturb: one shared multiplier forms the near and far heights in turn.
    assign coef_w      = (slot_reg == '0) ? NEAR_Q16 : FAR_Q16;
    assign pert_prod_w = amt_reg * $signed(coef_w);

    assign target_w = $signed({2'b00, hit_col}) + $signed(TGT_W'(slot_reg))
                      - $signed(TGT_W'(HIT_SLOT));
    assign target_in_row = (target_w >= 0) && (target_w < $signed(TGT_W'(n_used)));

    always_comb
    begin
        if (slot_reg == HIT_SLOT)
            pert_h_w = amt_reg;
        else if ((slot_reg == HIT_SLOT - COUNT_W'(1)) || (slot_reg == HIT_SLOT + COUNT_W'(1)))
            pert_h_w = near_reg;
        else
            pert_h_w = far_reg;
    end

    // Result pass: a pending read word moves to the output register when it is free.
    assign move  = rd_pending_reg && (!out_valid_reg || !result_stall);
    assign issue = (state_reg == ST_OUT) && (slot_reg < n_used) && (!rd_pending_reg || move);

    always_comb
    begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        active_next = active_reg;
        commit_next = commit_reg;
        div_start   = 1'b0;
        pipe_clear  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (request_accept)
                begin
                    slot_next = '0;
                    if (request.operation == OP_PERTURB)
                    begin
                        state_next = ST_DIV;
                        div_start  = 1'b1;
                    end
                    else if (active_reg)
                    begin
                        state_next = ST_COMP;
                        pipe_clear = 1'b1;
                    end
                    else
                    begin
                        state_next  = ST_OUT;
                        commit_next = 1'b0;
                    end
                end
            end
            ST_DIV:
            begin
                if (slot_reg < PROD_STEPS)
                    slot_next = slot_reg + COUNT_W'(1);
                if (div_done)
                begin
                    state_next = ST_PERT;
                    slot_next  = '0;
                end
            end
            ST_PERT:
            begin
                if (slot_reg == LAST_SLOT)
                begin
                    active_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                    slot_next = slot_reg + COUNT_W'(1);
            end
            ST_COMP:
            begin
                // One extra slot past the last column closes the right edge.
                if (slot_reg <= n_used)
                    slot_next = slot_reg + COUNT_W'(1);
                else if (!feed_valid_reg && !pipe_busy)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (spread_small)
                begin
                    active_next = 1'b0;
                    commit_next = 1'b0;
                end
                else
                    commit_next = 1'b1;
                slot_next  = '0;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (issue)
                    slot_next = slot_reg + COUNT_W'(1);
                if ((slot_reg == n_used) && !rd_pending_reg)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (issue)
            rd_pending_next = 1'b1;
        else if (move)
            rd_pending_next = 1'b0;
        else
            rd_pending_next = rd_pending_reg;

        if (move)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slot_reg         <= '0;
            active_reg       <= 1'b0;
            commit_reg       <= 1'b0;
            rd_pending_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            feed_valid_reg   <= 1'b0;
            max_slope_reg    <= MAX_SLOPE_RESET;
            column_width_reg <= COLUMN_WIDTH_RESET;
            column_count_reg <= COLUMN_COUNT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            slot_reg       <= slot_next;
            active_reg     <= active_next;
            commit_reg     <= commit_next;
            rd_pending_reg <= rd_pending_next;
            out_valid_reg  <= out_valid_next;
            feed_valid_reg <= (state_reg == ST_COMP) && (slot_reg <= n_used);
            if (cfg_accept)
            begin
                unique case (cfg_index)
                    CFG_MAX_SLOPE:    max_slope_reg    <= cfg_data[CFG_SLOPE_W-1:0];
                    CFG_COLUMN_WIDTH: column_width_reg <= cfg_data[CFG_WIDTH_W-1:0];
                    CFG_COLUMN_COUNT: column_count_reg <= cfg_data[CFG_COUNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (request_accept)
        begin
            dt_reg  <= request.time_step;
            amt_reg <= request.amount;
        end
        if ((state_reg == ST_DIV) && (slot_reg == '0))
            near_reg <= pert_prod_w[47:16];
        if ((state_reg == ST_DIV) && (slot_reg == COUNT_W'(1)))
            far_reg <= pert_prod_w[47:16];
        feed_idx_reg <= slot_reg;
        if (issue)
            pend_idx_reg <= slot_reg[COL_AW-1:0];
        if (move)
        begin
            out_reg.column_index   <= pend_idx_reg;
            out_reg.height         <= commit_reg ? nh_data : col_h;
            out_reg.surface_active <= active_reg;
            out_reg.last           <= ((COUNT_W'(pend_idx_reg) + COUNT_W'(1)) == n_used);
        end
    end

    // Memory port steering for the perturb, update and result passes.
    always_comb
    begin
        col_rd.en   = ((state_reg == ST_COMP) && (slot_reg < n_used))
                      || (issue && !commit_reg);
        col_rd.addr = slot_reg[COL_AW-1:0];
        nh_rd.en    = issue && commit_reg;
        nh_rd.addr  = slot_reg[COL_AW-1:0];

        col_wr.we_h = 1'b0;
        col_wr.we_v = 1'b0;
        col_wr.addr = pipe_wr.addr;
        col_wr.h    = nh_data;
        col_wr.v    = pipe_wr.vel;
        if (state_reg == ST_PERT)
        begin
            col_wr.we_h = target_in_row;
            col_wr.addr = target_w[COL_AW-1:0];
            col_wr.h    = pert_h_w;
        end
        else if (state_reg == ST_COMP)
            col_wr.we_v = pipe_wr.en;
        else if (state_reg == ST_OUT)
        begin
            col_wr.we_h = move && commit_reg;
            col_wr.addr = pend_idx_reg;
        end

        nh_wr.en   = pipe_wr.en;
        nh_wr.addr = pipe_wr.addr;
        nh_wr.data = pipe_wr.nh;
    end

    wcws_state_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .col_rd  (col_rd),
        .col_wr  (col_wr),
        .nh_rd   (nh_rd),
        .nh_wr   (nh_wr),
        .col_h   (col_h),
        .col_v   (col_v),
        .nh_data (nh_data)
    );

    wcws_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (request.position),
        .divisor  ((column_width_reg == '0) ? CFG_WIDTH_W'(1) : column_width_reg),
        .done     (div_done),
        .quotient (hit_col)
    );

    wcws_column_pipe u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (pipe_clear),
        .feed_valid   (feed_valid_reg),
        .feed_idx     (feed_idx_reg),
        .n_used       (n_used),
        .rd_h         (col_h),
        .rd_v         (col_v),
        .time_step    (dt_reg),
        .max_slope    (max_slope_reg),
        .wr           (pipe_wr),
        .busy         (pipe_busy),
        .spread_small (spread_small)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `WCWS_ASSERT_IMPLY(a_no_height_write_in_update, state_reg == ST_COMP, !col_wr.we_h, "height written during update pass")
    `WCWS_ASSERT_IMPLY(a_drained_before_decide, state_reg == ST_DECIDE, !pipe_busy, "update pipeline not drained at decision")
    `WCWS_ASSERT_NEXT(a_pending_word_held, rd_pending_reg && !move, $stable(pend_idx_reg), "pending result word changed while stalled")
    `WCWS_ASSERT_IMPLY(a_result_pass_bound, state_reg == ST_OUT, slot_reg <= n_used, "result pass ran past the last column")

endmodule
